[design/bounded_wrap_counter_cas_assert.svh]
// Assertion macros used by the bounded wrap counter top-level design file.
`ifndef BOUNDED_WRAP_COUNTER_CAS_ASSERT_SVH
`define BOUNDED_WRAP_COUNTER_CAS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bwc_pkg.sv]
// Types and constants of the bounded wrap counter.
package bwc_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned TallyWidth = 32;
    localparam int unsigned IndexWidth = 3;

    typedef enum logic [1:0] {
        FUNC_FETCH_DEFAULT = 2'd0,
        FUNC_FETCH_GIVEN   = 2'd1,
        FUNC_WRITE         = 2'd2,
        FUNC_CAS           = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [IndexWidth-1:0] {
        REG_MINIMUM = 3'd0,
        REG_MAXIMUM = 3'd1,
        REG_STEP    = 3'd2,
        REG_WRAP    = 3'd3,
        REG_INITIAL = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [ValueWidth-1:0] minimum_value;
        logic [ValueWidth-1:0] maximum_value;
        logic [ValueWidth-1:0] default_step;
        logic                  wrap_enable;
        logic                  init_load;    // pulse: load initial value into counter
        logic [ValueWidth-1:0] reload_value;
    } cfg_t;

    typedef struct packed {
        status_t               status;
        logic [ValueWidth-1:0] updated_count;
        logic                  fetch_ok;
        logic                  update_ok;
    } alu_res_t;

    localparam logic [ValueWidth-1:0] MinimumReset = 64'h0000_0000_0000_0000;
    localparam logic [ValueWidth-1:0] MaximumReset = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ValueWidth-1:0] StepReset    = 64'h0000_0000_0000_0001;
    localparam logic [ValueWidth-1:0] InitialReset = 64'h0000_0000_0000_0000;

endpackage

[design/bounded_wrap_counter_cas.sv]
// Bounded wrapping 64-bit counter with fetch-and-add, write and compare-and-set.
// Throughput is one transaction per clock: an input register holds the accepted
// transaction, a single combinational pass (65-bit add, range compares, one wrap
// correction) evaluates it against the counter, and the result register presents
// it. The counter and the fetch and update tallies change as a transaction moves
// from the input register to the result register, so each transaction sees the
// effect of the one before it. A stalled output holds both registers full;
// in_ready then falls. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no transaction is in flight; the block
// does not enforce this. Writing the initial value register (index 4) also
// reloads the counter.
`include "bounded_wrap_counter_cas_assert.svh"

module bounded_wrap_counter_cas (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bwc_pkg::IndexWidth-1:0]   cfg_index,
    input  logic [bwc_pkg::ValueWidth-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [bwc_pkg::ValueWidth-1:0]   operand,
    input  logic [bwc_pkg::ValueWidth-1:0]   expected,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [bwc_pkg::ValueWidth-1:0]   old_value,
    output logic [bwc_pkg::ValueWidth-1:0]   count_after,
    output logic [bwc_pkg::TallyWidth-1:0]   fetches_done,
    output logic [bwc_pkg::TallyWidth-1:0]   updates_done
);
    import bwc_pkg::*;

    cfg_t                  cfg;
    alu_res_t              res;

    logic                  in_valid_reg;
    logic [1:0]            func_reg;
    logic [ValueWidth-1:0] operand_reg;
    logic [ValueWidth-1:0] expected_reg;

    logic [ValueWidth-1:0] count_value_reg;
    logic [ValueWidth-1:0] count_value_next;
    logic [TallyWidth-1:0] fetch_tally_reg;
    logic [TallyWidth-1:0] fetch_tally_next;
    logic [TallyWidth-1:0] update_tally_reg;
    logic [TallyWidth-1:0] update_tally_next;

    logic                  out_valid_reg;
    status_t               status_reg;
    logic [ValueWidth-1:0] old_value_reg;
    logic [ValueWidth-1:0] count_after_reg;
    logic [TallyWidth-1:0] fetches_reg;
    logic [TallyWidth-1:0] updates_reg;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    bwc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bwc_alu u_alu (
        .func     (func_reg),
        .operand  (operand_reg),
        .expected (expected_reg),
        .count    (count_value_reg),
        .cfg      (cfg),
        .res      (res)
    );

    // Handshake: advance into the result register when it is empty or draining
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Hold the accepted transaction in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg     <= func;
            operand_reg  <= operand;
            expected_reg <= expected;
        end
    end

    // Next counter and tallies: a reload of the initial value, else the transaction leaving the input register
    always_comb
    begin
        count_value_next  = count_value_reg;
        fetch_tally_next  = fetch_tally_reg;
        update_tally_next = update_tally_reg;
        if (cfg.init_load)
            count_value_next = cfg.reload_value;
        else if (advance)
        begin
            count_value_next  = res.updated_count;
            fetch_tally_next  = fetch_tally_reg + TallyWidth'(res.fetch_ok);
            update_tally_next = update_tally_reg + TallyWidth'(res.update_ok);
        end
    end

    // Advance the counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_value_reg  <= InitialReset;
            fetch_tally_reg  <= '0;
            update_tally_reg <= '0;
        end
        else
        begin
            count_value_reg  <= count_value_next;
            fetch_tally_reg  <= fetch_tally_next;
            update_tally_reg <= update_tally_next;
        end
    end

    // Result register valid: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg      <= res.status;
            old_value_reg   <= count_value_reg;
            count_after_reg <= res.updated_count;
            fetches_reg     <= fetch_tally_next;
            updates_reg     <= update_tally_next;
        end
    end

    // Drive the output channel
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign old_value     = old_value_reg;
    assign count_after   = count_after_reg;
    assign fetches_done  = fetches_reg;
    assign updates_done  = updates_reg;

    // Checks
    `BWC_ASSERT_NOW(a_refused_keeps_value,
        out_valid_reg && (status_reg != STATUS_OK),
        count_after_reg == old_value_reg,
        "refused transaction reports a changed counter")
    `BWC_ASSERT_NEXT(a_tallies_mirror_state,
        advance,
        (fetches_reg == fetch_tally_reg) && (updates_reg == update_tally_reg),
        "result tallies differ from stored tallies")
    `BWC_ASSERT_NEXT(a_counter_stable_when_idle,
        !advance && !cfg.init_load,
        $stable(count_value_reg),
        "counter changed without a transaction or reload")
    `BWC_ASSERT_NOW(a_ready_when_output_empty,
        !out_valid_reg,
        in_ready,
        "input stalled while result register is empty")
    `BWC_ASSERT_NEXT(a_result_matches_count,
        advance,
        count_after_reg == count_value_reg,
        "reported value differs from stored counter")

endmodule

[design/bwc_cfg.sv]
// Configuration register file of the bounded wrap counter.
module bwc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bwc_pkg::IndexWidth-1:0]       cfg_index,
    input  logic [bwc_pkg::ValueWidth-1:0]       cfg_data,
    output bwc_pkg::cfg_t                        cfg
);
    import bwc_pkg::*;

    logic [ValueWidth-1:0] minimum_reg;
    logic [ValueWidth-1:0] maximum_reg;
    logic [ValueWidth-1:0] step_reg;
    logic                  wrap_reg;
    logic [ValueWidth-1:0] initial_reg;
    logic                  init_hit;

    // Decode a write to the initial value register
    assign init_hit = cfg_we && (reg_index_t'(cfg_index) == REG_INITIAL);

    // Capture register writes; ignore indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimum_reg <= MinimumReset;
            maximum_reg <= MaximumReset;
            step_reg    <= StepReset;
            wrap_reg    <= 1'b0;
            initial_reg <= InitialReset;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MINIMUM: minimum_reg <= cfg_data;
                REG_MAXIMUM: maximum_reg <= cfg_data;
                REG_STEP:    step_reg    <= cfg_data;
                REG_WRAP:    wrap_reg    <= cfg_data[0];
                REG_INITIAL: initial_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Present the settings as one bundle
    always_comb
    begin
        cfg.minimum_value = minimum_reg;
        cfg.maximum_value = maximum_reg;
        cfg.default_step  = step_reg;
        cfg.wrap_enable   = wrap_reg;
        cfg.init_load     = init_hit;
        cfg.reload_value  = init_hit ? cfg_data : initial_reg;
    end

endmodule

[design/bwc_alu.sv]
// Single-pass evaluation of one counter transaction against the current count.
module bwc_alu (
    input  logic [1:0]                     func,
    input  logic [bwc_pkg::ValueWidth-1:0] operand,
    input  logic [bwc_pkg::ValueWidth-1:0] expected,
    input  logic [bwc_pkg::ValueWidth-1:0] count,
    input  bwc_pkg::cfg_t                  cfg,
    output bwc_pkg::alu_res_t              res
);
    import bwc_pkg::*;

    logic [ValueWidth-1:0] step;
    logic [ValueWidth:0]   sum_wide;
    logic [ValueWidth-1:0] sum_low;
    logic                  above;
    logic                  below;
    logic [ValueWidth-1:0] wrap_high;
    logic [ValueWidth-1:0] wrap_low;
    logic                  operand_out;

    // Form the exact sum one bit wider than the counter
    assign step     = (func_t'(func) == FUNC_FETCH_DEFAULT) ? cfg.default_step : operand;
    assign sum_wide = {count[ValueWidth-1], count} + {step[ValueWidth-1], step};
    assign sum_low  = sum_wide[ValueWidth-1:0];

    // Range tests on the wide sum; above takes priority over below
    assign above = $signed(sum_wide) >
                   $signed({cfg.maximum_value[ValueWidth-1], cfg.maximum_value});
    assign below = !above && ($signed(sum_wide) <
                   $signed({cfg.minimum_value[ValueWidth-1], cfg.minimum_value}));

    // Wrap once around the range, modulo 2^64
    assign wrap_high = cfg.minimum_value + (sum_low - cfg.maximum_value - 64'd1);
    assign wrap_low  = cfg.maximum_value - (cfg.minimum_value - sum_low - 64'd1);

    // Range test for a written value
    assign operand_out = ($signed(operand) < $signed(cfg.minimum_value)) ||
                         ($signed(operand) > $signed(cfg.maximum_value));

    // Pick the outcome for the function code
    always_comb
    begin
        res.status        = STATUS_OK;
        res.updated_count = count;
        res.fetch_ok      = 1'b0;
        res.update_ok     = 1'b0;
        unique case (func_t'(func))
            FUNC_FETCH_DEFAULT, FUNC_FETCH_GIVEN:
            begin
                priority if ((above || below) && !cfg.wrap_enable)
                begin
                    res.status = STATUS_RANGE;
                end
                else if (above)
                begin
                    res.updated_count = wrap_high;
                    res.fetch_ok      = 1'b1;
                end
                else if (below)
                begin
                    res.updated_count = wrap_low;
                    res.fetch_ok      = 1'b1;
                end
                else
                begin
                    res.updated_count = sum_low;
                    res.fetch_ok      = 1'b1;
                end
            end
            FUNC_WRITE:
            begin
                if (operand_out)
                    res.status = STATUS_RANGE;
                else
                    res.updated_count = operand;
            end
            FUNC_CAS:
            begin
                priority if (operand_out)
                    res.status = STATUS_RANGE;
                else if (count != expected)
                    res.status = STATUS_MISMATCH;
                else
                begin
                    res.updated_count = operand;
                    res.update_ok     = 1'b1;
                end
            end
        endcase
    end

endmodule

[verif/tb_bounded_wrap_counter_cas.sv]
// Testbench for the bounded wrap counter: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_bounded_wrap_counter_cas;
    import bwc_pkg::*;

    localparam int unsigned NumPhases   = 12;
    localparam int unsigned PhaseItems  = 152;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 4;
    localparam int unsigned MaxReports  = 10;
    localparam logic [ValueWidth-1:0] SignedMax = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ValueWidth-1:0] SignedMin = 64'h8000_0000_0000_0000;

    typedef struct packed {
        status_t               status;
        logic [ValueWidth-1:0] old_value;
        logic [ValueWidth-1:0] cur_value;
        logic [TallyWidth-1:0] fetches;
        logic [TallyWidth-1:0] updates;
    } counter_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [IndexWidth-1:0] cfg_index;
    logic [ValueWidth-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    func_t                 func;
    logic [ValueWidth-1:0] operand;
    logic [ValueWidth-1:0] expected;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [ValueWidth-1:0] old_value;
    logic [ValueWidth-1:0] count_after;
    logic [TallyWidth-1:0] fetches_done;
    logic [TallyWidth-1:0] updates_done;

    // Predicted register file and counter state
    logic [ValueWidth-1:0] lim_min;
    logic [ValueWidth-1:0] lim_max;
    logic [ValueWidth-1:0] step_default;
    logic                  wrap_on;
    logic [ValueWidth-1:0] shadow_count;
    logic [TallyWidth-1:0] shadow_fetches;
    logic [TallyWidth-1:0] shadow_updates;

    counter_result_t pending_results[$];
    counter_result_t got_result;
    counter_result_t want_result;

    int unsigned cycles = 0;
    int unsigned failures = 0;
    int unsigned reports = 0;
    int unsigned results_seen = 0;
    int unsigned txn_count = 0;
    int unsigned reg_writes = 0;
    int unsigned stall_left = 0;
    int unsigned func_count[4] = '{0, 0, 0, 0};
    int unsigned status_count[4] = '{0, 0, 0, 0};
    bit          calm = 1'b0;

    bounded_wrap_counter_cas dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .operand       (operand),
        .expected      (expected),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .old_value     (old_value),
        .count_after   (count_after),
        .fetches_done  (fetches_done),
        .updates_done  (updates_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycles, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Stall the result side in random bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                out_ready = 1'b1;
            end
            else if (stall_left != 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                stall_left = $urandom_range(0, 9);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    function automatic logic [ValueWidth-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit in_window(logic [ValueWidth-1:0] v);
        return !($signed(v) < $signed(lim_min)) && !($signed(lim_max) < $signed(v));
    endfunction

    // Apply one transaction to the predicted state and return its result
    function automatic counter_result_t predict_counter_op(func_t f, logic [ValueWidth-1:0] op,
                                                           logic [ValueWidth-1:0] want);
        counter_result_t    r;
        logic [63:0]        step_val;
        logic [63:0]        sum_low;
        logic signed [64:0] sum_wide;
        logic               above;
        logic               below;
        r.status = STATUS_OK;
        r.old_value = shadow_count;
        case (f)
            FUNC_FETCH_DEFAULT, FUNC_FETCH_GIVEN:
            begin
                step_val = (f == FUNC_FETCH_DEFAULT) ? step_default : op;
                sum_wide = $signed({shadow_count[63], shadow_count})
                         + $signed({step_val[63], step_val});
                sum_low = sum_wide[63:0];
                above = sum_wide > $signed({lim_max[63], lim_max});
                below = !above && (sum_wide < $signed({lim_min[63], lim_min}));
                // wrap once, or refuse
                if (above || below)
                begin
                    if (!wrap_on)
                        r.status = STATUS_RANGE;
                    else if (above)
                        sum_low = lim_min + (sum_low - lim_max - 64'd1);
                    else
                        sum_low = lim_max - (lim_min - sum_low - 64'd1);
                end
                if (r.status == STATUS_OK)
                begin
                    shadow_count = sum_low;
                    shadow_fetches = shadow_fetches + 32'd1;
                end
            end
            FUNC_WRITE:
            begin
                if (!in_window(op))
                    r.status = STATUS_RANGE;
                else
                    shadow_count = op;
            end
            default:
            begin
                // range test first, then the compare
                if (!in_window(op))
                    r.status = STATUS_RANGE;
                else if (shadow_count != want)
                    r.status = STATUS_MISMATCH;
                else
                begin
                    shadow_count = op;
                    shadow_updates = shadow_updates + 32'd1;
                end
            end
        endcase
        r.cur_value = shadow_count;
        r.fetches = shadow_fetches;
        r.updates = shadow_updates;
        return r;
    endfunction

    // Check every result leaving the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got_result.status = status_t'(status);
            got_result.old_value = old_value;
            got_result.cur_value = count_after;
            got_result.fetches = fetches_done;
            got_result.updates = updates_done;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (reports < MaxReports)
                    $display("unexpected result: status %0d old %h cur %h",
                             status, old_value, count_after);
                reports++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.status !== want_result.status
                    || got_result.old_value !== want_result.old_value
                    || got_result.cur_value !== want_result.cur_value
                    || got_result.fetches !== want_result.fetches
                    || got_result.updates !== want_result.updates)
                begin
                    failures++;
                    if (reports < MaxReports)
                    begin
                        $display("mismatch on result %0d (exp/got):", results_seen);
                        $display("  status %0d/%0d old %h/%h cur %h/%h",
                                 want_result.status, got_result.status,
                                 want_result.old_value, got_result.old_value,
                                 want_result.cur_value, got_result.cur_value);
                        $display("  fetches %0d/%0d updates %0d/%0d",
                                 want_result.fetches, got_result.fetches,
                                 want_result.updates, got_result.updates);
                    end
                    reports++;
                end
            end
        end
    end

    // Send one transaction, record its predicted result on acceptance
    task automatic send_txn(func_t f, logic [ValueWidth-1:0] op, logic [ValueWidth-1:0] want);
        counter_result_t r;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid = 1'b1;
        func = f;
        operand = op;
        expected = want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = predict_counter_op(f, op, want);
        pending_results.insert(pending_results.size(), r);
        txn_count++;
        func_count[f]++;
        status_count[r.status]++;
    endtask

    // Hold the sender until every predicted result has been checked
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [IndexWidth-1:0] idx, logic [ValueWidth-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_MINIMUM: lim_min = data;
            REG_MAXIMUM: lim_max = data;
            REG_STEP:    step_default = data;
            REG_WRAP:    wrap_on = data[0];
            REG_INITIAL: shadow_count = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(logic [ValueWidth-1:0] lo, logic [ValueWidth-1:0] hi,
                                logic [ValueWidth-1:0] stp, bit wrp,
                                logic [ValueWidth-1:0] init);
        wait_drain();
        write_reg(REG_MINIMUM, lo);
        write_reg(REG_MAXIMUM, hi);
        write_reg(REG_STEP, stp);
        // only bit 0 of the wrap register counts
        write_reg(REG_WRAP, (rand64() & ~64'd1) | {63'd0, wrp});
        write_reg(REG_INITIAL, init);
    endtask

    // Values near and across the window edges, inside it, or anywhere
    function automatic logic [ValueWidth-1:0] pick_value();
        logic [ValueWidth-1:0] span;
        span = lim_max - lim_min;
        case ($urandom_range(0, 7))
            0: return lim_min;
            1: return lim_max;
            2: return lim_min - 64'd1;
            3: return lim_max + 64'd1;
            4: return rand64();
            default:
            begin
                if ($signed(lim_max) < $signed(lim_min) || span == '1)
                    return rand64();
                return lim_min + (rand64() % (span + 64'd1));
            end
        endcase
    endfunction

    function automatic logic [ValueWidth-1:0] pick_step();
        case ($urandom_range(0, 6))
            0: return SignedMax;
            1: return SignedMin;
            2: return rand64();
            3: return lim_max - lim_min + 64'd1;
            default: return 64'($urandom_range(0, 40)) - 64'd20;
        endcase
    endfunction

    function automatic logic [ValueWidth-1:0] small_signed();
        logic [31:0] w;
        w = $urandom;
        return {{32{w[31]}}, w};
    endfunction

    // Choose a window shape, step, wrap mode and start value for one phase
    task automatic pick_setting(int unsigned kind);
        logic [ValueWidth-1:0] lo;
        logic [ValueWidth-1:0] hi;
        logic [ValueWidth-1:0] stp;
        logic [ValueWidth-1:0] init;
        case (kind % 6)
            0:
            begin
                lo = MinimumReset;
                hi = MaximumReset;
            end
            1:
            begin
                lo = SignedMin;
                hi = SignedMax;
            end
            2:
            begin
                lo = small_signed();
                hi = lo + 64'($urandom_range(1, 200));
            end
            3:
            begin
                lo = small_signed();
                hi = lo + 64'($urandom_range(0, 3));
            end
            4:
            begin
                hi = small_signed();
                lo = hi + 64'($urandom_range(1, 100));
            end
            default:
            begin
                lo = SignedMin + 64'($urandom_range(0, 50));
                hi = SignedMax - 64'($urandom_range(0, 50));
            end
        endcase
        case ($urandom_range(0, 4))
            0: stp = 64'd1;
            1: stp = -64'sd1;
            2: stp = ($urandom_range(0, 1) != 0) ? SignedMax : SignedMin;
            3: stp = rand64();
            default: stp = 64'($urandom_range(0, 60)) - 64'd30;
        endcase
        init = lo + 64'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            init = rand64();
        apply_config(lo, hi, stp, 1'($urandom_range(0, 1)), init);
    endtask

    // Mostly well-formed traffic: compare-and-set usually names the live value
    task automatic run_phase(int unsigned n, bit pause_midway);
        func_t                 f;
        logic [ValueWidth-1:0] op;
        logic [ValueWidth-1:0] want;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                wait_drain();
            f = func_t'($urandom_range(0, 3));
            case (f)
                FUNC_FETCH_GIVEN: op = pick_step();
                FUNC_FETCH_DEFAULT: op = rand64();
                default: op = pick_value();
            endcase
            want = rand64();
            if (f == FUNC_CAS && $urandom_range(0, 3) != 0)
                want = shadow_count;
            else if (f == FUNC_CAS && $urandom_range(0, 1) != 0)
                want = pick_value();
            send_txn(f, op, want);
        end
    endtask

    task automatic test_reset_state();
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        send_txn(FUNC_FETCH_GIVEN, SignedMax, SignedMin);
        send_txn(FUNC_CAS, 64'd5, 64'd1);
    endtask

    task automatic test_range_edges();
        send_txn(FUNC_WRITE, SignedMax, '1);
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        send_txn(FUNC_WRITE, '0, '0);
        send_txn(FUNC_FETCH_GIVEN, -64'sd1, '0);
        send_txn(FUNC_WRITE, -64'sd1, '0);
        send_txn(FUNC_CAS, -64'sd1, 64'd3);
        send_txn(FUNC_CAS, 64'd7, 64'd3);
        send_txn(FUNC_CAS, 64'd7, 64'd0);
    endtask

    task automatic test_wrap_cases();
        // small window: wrap past the top and the bottom
        apply_config(-64'sd10, 64'd10, 64'd5, 1'b1, 64'd8);
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        send_txn(FUNC_FETCH_GIVEN, -64'sd7, '0);
        // full range: sums beyond 64 bits in both directions
        apply_config(SignedMin, SignedMax, 64'd1, 1'b1, SignedMax);
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        send_txn(FUNC_FETCH_GIVEN, SignedMin, '0);
        send_txn(FUNC_FETCH_GIVEN, SignedMax, '0);
        send_txn(FUNC_FETCH_GIVEN, SignedMax, '0);
    endtask

    task automatic test_inverted_range();
        apply_config(64'd5, -64'sd5, 64'd1, 1'b1, '0);
        send_txn(FUNC_WRITE, '0, '0);
        send_txn(FUNC_CAS, '0, '0);
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        wait_drain();
        write_reg(REG_WRAP, 64'hFFFF_FFFF_FFFF_FFFE);
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
    endtask

    task automatic test_register_writes();
        apply_config(MinimumReset, MaximumReset, StepReset, 1'b0, 64'd3);
        // writes to unused indexes must leave everything alone
        for (int unsigned k = REG_INITIAL + 1; k < (1 << IndexWidth); k++)
            write_reg(IndexWidth'(k), rand64());
        send_txn(FUNC_FETCH_DEFAULT, '0, '0);
        send_txn(FUNC_FETCH_GIVEN, '0, '1);
    endtask

    task automatic test_random_traffic();
        for (int unsigned p = 0; p < NumPhases; p++)
        begin
            pick_setting(p);
            // no idling on either side in the closing phases
            calm = (p >= NumPhases - 2);
            run_phase(PhaseItems, p == 5);
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MINIMUM;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_FETCH_DEFAULT;
        operand = '0;
        expected = '0;
        lim_min = MinimumReset;
        lim_max = MaximumReset;
        step_default = StepReset;
        wrap_on = 1'b0;
        shadow_count = InitialReset;
        shadow_fetches = '0;
        shadow_updates = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_range_edges();
        test_wrap_cases();
        test_inverted_range();
        test_register_writes();
        test_random_traffic();

        $display("%0d transactions: %0d fetch default, %0d fetch given, %0d write, %0d cas",
                 txn_count, func_count[FUNC_FETCH_DEFAULT], func_count[FUNC_FETCH_GIVEN],
                 func_count[FUNC_WRITE], func_count[FUNC_CAS]);
        $display("%0d reg writes; %0d results checked: %0d ok, %0d out of range, %0d mismatch",
                 reg_writes, results_seen, status_count[STATUS_OK],
                 status_count[STATUS_RANGE], status_count[STATUS_MISMATCH]);
        $display("%0d failures", failures);
        if (failures == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
